// ----- sv/assert_macros.svh -----
// Assertion macros for the tunnel-effect pixel mapper.
// No dependencies; include before writing any assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Clocked check with synchronous active-low reset as disable.
`define TEPM_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Clocked check that also holds during reset.
`define TEPM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TEPM_ASSERT(lbl, clk, rstn, prop, msg)
`define TEPM_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ----- sv/tepm_pkg.sv -----
// Shared types, constants and helper functions of the tunnel-effect pixel mapper.
// No dependencies.
`timescale 1ns / 1ps
package tepm_pkg;

    localparam int CORDIC_STEPS = 17;
    localparam int DEPTH_BITS   = 16;
    localparam int ANG_FRAC     = 16;

    // configuration register indexes
    localparam logic [1:0] CFG_CENTER_X       = 2'd0;
    localparam logic [1:0] CFG_CENTER_Y       = 2'd1;
    localparam logic [1:0] CFG_DISTANCE_SCALE = 2'd2;

    localparam logic [8:0]  RST_CENTER_X       = 9'd256;
    localparam logic [8:0]  RST_CENTER_Y       = 9'd256;
    localparam logic [15:0] RST_DISTANCE_SCALE = 16'd7680;

    typedef logic signed [27:0] t_xy;
    typedef logic signed [25:0] t_ang;

    // one beat of work as it moves along the cell chain
    typedef struct packed {
        logic        valid;
        t_xy         x;
        t_xy         y;
        t_ang        z;
        logic        ay_zero;
        logic        ax_zero;
        logic        diag;
        logic        neg_x;
        logic        neg_y;
        logic        d2_zero;
        logic [19:0] d2;
        logic [31:0] s2;
        logic [31:0] p;
        logic [35:0] q_acc;
        logic [15:0] q;
    } t_cell;

    // atan(2^-i) in units of pi/2^23, rounded to nearest
    function automatic logic [22:0] atan_step(input logic [4:0] i);
        logic [22:0] r;
        case (i)
            5'd0:    r = 23'd2097152;
            5'd1:    r = 23'd1238021;
            5'd2:    r = 23'd654136;
            5'd3:    r = 23'd332050;
            5'd4:    r = 23'd166669;
            5'd5:    r = 23'd83416;
            5'd6:    r = 23'd41718;
            5'd7:    r = 23'd20860;
            5'd8:    r = 23'd10430;
            5'd9:    r = 23'd5215;
            5'd10:   r = 23'd2608;
            5'd11:   r = 23'd1304;
            5'd12:   r = 23'd652;
            5'd13:   r = 23'd326;
            5'd14:   r = 23'd163;
            5'd15:   r = 23'd81;
            5'd16:   r = 23'd41;
            default: r = 23'd0;
        endcase
        return r;
    endfunction

    // arithmetic right shift that truncates toward zero
    function automatic t_xy shr_tz(input t_xy v, input logic [4:0] s);
        logic [27:0] m;
        m = v[27] ? 28'(-v) : 28'(v);
        m = m >> s;
        return v[27] ? t_xy'(-m) : t_xy'(m);
    endfunction

endpackage

// ----- sv/tepm_cell.sv -----
// One cell of the mapper chain: a CORDIC vectoring step and, for stages below DEPTH_BITS, one depth bit.
// Depends on tepm_pkg.
`timescale 1ns / 1ps
module tepm_cell import tepm_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,
    input  logic [4:0] i_stage,
    input  t_cell      i_cell,
    output t_cell      o_cell
);

    t_cell       r_cell;
    t_cell       n_cell;
    t_xy         w_xs;
    t_xy         w_ys;
    logic [3:0]  w_k;
    logic [53:0] w_trial;
    logic [22:0] w_step;

    // rotate toward the x axis and trial one bit of the depth root
    always_comb begin
        n_cell = i_cell;
        w_xs   = shr_tz(i_cell.x, i_stage);
        w_ys   = shr_tz(i_cell.y, i_stage);
        w_step = atan_step(i_stage);
        if (!i_cell.y[27] && (i_cell.y != '0)) begin
            n_cell.x = i_cell.x + w_ys;
            n_cell.y = i_cell.y - w_xs;
            n_cell.z = i_cell.z + t_ang'({3'b0, w_step});
        end else begin
            n_cell.x = i_cell.x - w_ys;
            n_cell.y = i_cell.y + w_xs;
            n_cell.z = i_cell.z - t_ang'({3'b0, w_step});
        end
        w_k     = 4'(5'(DEPTH_BITS - 1) - i_stage);
        w_trial = {22'b0, i_cell.p}
                + ({18'b0, i_cell.q_acc} << ({2'b0, w_k} + 6'd1))
                + ({34'b0, i_cell.d2} << {w_k, 1'b0});
        if ((i_stage < 5'(DEPTH_BITS)) && (w_trial <= {22'b0, i_cell.s2})) begin
            n_cell.p     = w_trial[31:0];
            n_cell.q_acc = i_cell.q_acc + ({16'b0, i_cell.d2} << w_k);
            n_cell.q     = i_cell.q | (16'd1 << w_k);
        end
    end

    // advance with the chain, clear valid on reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell.valid <= 1'b0;
        end else if (i_en) begin
            r_cell <= n_cell;
        end
    end

    assign o_cell = r_cell;

endmodule

// ----- sv/tunnel_effect_pixel_mapper.sv -----
// Channel   Dir  Fields (low bit up)
// s_axis    in   pixel_column[8:0], pixel_row[17:9]
// m_axis    out  texel_color[31:0], depth_index[38:32], angle_index[45:39]
// cfg       in   index 0 center_x, 1 center_y, 2 distance_scale
//
// One pixel per cycle unless m_axis stalls; entry register, 17 cells, output
// register. Each cell does one CORDIC step and, but for the last, one bit of
// the depth root. Reset is synchronous, active low, clears the valid flags and
// sets the configuration registers to their defaults. A stall on m_axis freezes
// the whole chain and drops s_axis tready in the same cycle.
// Depends on tepm_pkg, tepm_cell and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module tunnel_effect_pixel_mapper import tepm_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,   // pixel_column[8:0], pixel_row[17:9], zero pad
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [47:0] o_m_axis_tdata,   // texel_color[31:0], depth[38:32], angle[45:39]
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    logic [8:0]  r_center_x;
    logic [8:0]  r_center_y;
    logic [15:0] r_scale;
    logic        w_en;
    t_cell       r_front;
    t_cell       n_front;
    t_cell       w_chain [0:CORDIC_STEPS];
    logic signed [9:0] w_dx;
    logic signed [9:0] w_dy;
    logic [8:0]  w_ax;
    logic [8:0]  w_ay;
    t_ang        w_z;
    t_ang        w_a;
    logic [7:0]  w_mag;
    logic [7:0]  w_sang;
    logic [6:0]  w_depth;
    logic [6:0]  w_angle;
    logic [6:0]  w_t;
    logic        r_out_valid;
    logic [47:0] r_out_data;
    logic [47:0] n_out_data;

    // configuration registers
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x <= RST_CENTER_X;
            r_center_y <= RST_CENTER_Y;
            r_scale    <= RST_DISTANCE_SCALE;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_CENTER_X:       r_center_x <= i_cfg_data[8:0];
                CFG_CENTER_Y:       r_center_y <= i_cfg_data[8:0];
                CFG_DISTANCE_SCALE: r_scale    <= i_cfg_data;
                default:            ;
            endcase
        end
    end

    // chain advances whenever the output register is free or being drained
    assign w_en            = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = w_en;

    // form offsets, squared distance and squared scale
    always_comb begin
        w_dx = $signed({1'b0, i_s_axis_tdata[8:0]}) - $signed({1'b0, r_center_x});
        w_dy = $signed({1'b0, i_s_axis_tdata[17:9]}) - $signed({1'b0, r_center_y});
        w_ax = w_dx[9] ? 9'(-w_dx) : w_dx[8:0];
        w_ay = w_dy[9] ? 9'(-w_dy) : w_dy[8:0];
        n_front         = '0;
        n_front.valid   = i_s_axis_tvalid;
        n_front.x       = t_xy'({3'b0, w_ax, 16'b0});
        n_front.y       = t_xy'({3'b0, w_ay, 16'b0});
        n_front.ay_zero = (w_ay == '0);
        n_front.ax_zero = (w_ax == '0);
        n_front.diag    = (w_ax == w_ay);
        n_front.neg_x   = w_dx[9];
        n_front.neg_y   = w_dy[9];
        n_front.d2      = 20'({11'b0, w_ax} * {11'b0, w_ax})
                        + 20'({11'b0, w_ay} * {11'b0, w_ay});
        n_front.d2_zero = n_front.ax_zero && n_front.ay_zero;
        n_front.s2      = {16'b0, r_scale} * {16'b0, r_scale};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front.valid <= 1'b0;
        end else if (w_en) begin
            r_front <= n_front;
        end
    end

    // row of cells
    assign w_chain[0] = r_front;
    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
        tepm_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_stage (5'(g)),
            .i_cell  (w_chain[g]),
            .o_cell  (w_chain[g+1])
        );
    end

    // clamp the angle, mirror by quadrant and pack the colour
    always_comb begin
        w_z = w_chain[CORDIC_STEPS].z;
        if (w_z < 0) begin
            w_z = '0;
        end else if (w_z > t_ang'(64 << ANG_FRAC)) begin
            w_z = t_ang'(64 << ANG_FRAC);
        end
        if (w_chain[CORDIC_STEPS].ay_zero) begin
            w_z = '0;
        end else if (w_chain[CORDIC_STEPS].ax_zero) begin
            w_z = t_ang'(64 << ANG_FRAC);
        end else if (w_chain[CORDIC_STEPS].diag) begin
            w_z = t_ang'(32 << ANG_FRAC);
        end
        w_a     = w_chain[CORDIC_STEPS].neg_x ? (t_ang'(128 << ANG_FRAC) - w_z) : w_z;
        w_mag   = w_a[23:16];
        w_sang  = w_chain[CORDIC_STEPS].neg_y ? 8'(-w_mag) : w_mag;
        w_angle = w_sang[6:0];
        w_depth = w_chain[CORDIC_STEPS].d2_zero ? 7'd0 : w_chain[CORDIC_STEPS].q[6:0];
        w_t     = w_depth ^ w_angle;
        n_out_data = {2'b0, w_angle, w_depth, 1'b0, w_t, 1'b0, w_t, 1'b0, w_t, 8'hff};
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_chain[CORDIC_STEPS].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    `TEPM_ASSERT(a_alpha, i_clk, i_rst_n, o_m_axis_tvalid |-> (o_m_axis_tdata[7:0] == 8'hff), "alpha byte not 0xff")
    `TEPM_ASSERT(a_bytes, i_clk, i_rst_n, o_m_axis_tvalid |-> ((o_m_axis_tdata[31:24] == o_m_axis_tdata[23:16]) && (o_m_axis_tdata[23:16] == o_m_axis_tdata[15:8])), "colour bytes differ")
    `TEPM_ASSERT(a_xor, i_clk, i_rst_n, o_m_axis_tvalid |-> (o_m_axis_tdata[30:24] == (o_m_axis_tdata[38:32] ^ o_m_axis_tdata[45:39])), "colour is not depth xor angle")

endmodule

// ----- tb/sv/tb_tunnel_effect_pixel_mapper.sv -----
// Testbench for the tunnel-effect pixel mapper: directed pixels, then random ones,
// checked against a behavioral angle/depth predictor. Depends on tepm_pkg and the DUT.
`timescale 1ns / 1ps
module tb_tunnel_effect_pixel_mapper;
    import tepm_pkg::*;

    localparam int LATENCY   = 19;
    localparam int CYCLE_CAP = 400000;
    localparam int N_RANDOM  = 1430;

    // register index with no register behind it; also marks "no write" in the table
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    typedef struct {
        logic [31:0] color;
        logic [6:0]  depth;
        logic [6:0]  angle;
    } texel_t;

    typedef struct {
        logic [1:0]  cfg_idx;   // CFG_* or CFG_UNUSED for "no write"
        logic [15:0] cfg_val;
        logic [8:0]  col;
        logic [8:0]  row;
        logic        known;     // depth/angle typed in below
        logic [6:0]  depth;
        logic [6:0]  angle;
    } vector_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_valid;
    logic        s_ready;
    logic [23:0] s_data;
    logic        m_valid;
    logic        m_ready;
    logic [47:0] m_data;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    // predictor copy of the registers
    logic [8:0]  ctr_x;
    logic [8:0]  ctr_y;
    logic [15:0] dscale;

    texel_t      texels_due[$];
    int          errors;
    int          cycles;
    int          results_seen;
    int          rx_wait;
    bit          hold_off;

    tunnel_effect_pixel_mapper i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(s_valid),
        .o_s_axis_tready(s_ready),
        .i_s_axis_tdata (s_data),
        .o_m_axis_tvalid(m_valid),
        .i_m_axis_tready(m_ready),
        .o_m_axis_tdata (m_data),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic longint trunc_shift(longint v, int s);
        if (v < 0) return -((-v) >>> s);
        return v >>> s;
    endfunction

    // first-quadrant angle in units of pi/2^23
    function automatic longint quadrant_phase(longint ax, longint ay);
        longint steps[17] = '{2097152, 1238021, 654136, 332050, 166669, 83416, 41718,
                              20860, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41};
        longint x, y, z, xs, ys;
        if (ay == 0) return 0;
        if (ax == 0) return longint'(64) << 16;
        if (ax == ay) return longint'(32) << 16;
        x = ax * 65536;
        y = ay * 65536;
        z = 0;
        for (int i = 0; i < 17; i++) begin
            xs = trunc_shift(x, i);
            ys = trunc_shift(y, i);
            if (y > 0) begin
                x = x + ys; y = y - xs; z += steps[i];
            end else begin
                x = x - ys; y = y + xs; z -= steps[i];
            end
        end
        if (z < 0) z = 0;
        if (z > (longint'(64) << 16)) z = longint'(64) << 16;
        return z;
    endfunction

    function automatic texel_t map_pixel(logic [8:0] col, logic [8:0] row);
        texel_t r;
        longint dx, dy, a, mag, q;
        longint unsigned d2, quot;
        logic [6:0] t;
        dx = longint'(col) - longint'(ctr_x);
        dy = longint'(row) - longint'(ctr_y);
        d2 = dx * dx + dy * dy;
        q = 0;
        if (d2 != 0) begin
            quot = (longint'(dscale) * longint'(dscale)) / d2;
            // integer square root: estimate, then step down and up to the exact floor
            q = longint'($sqrt(real'(quot)));
            while (q * q > quot) q--;
            while ((q + 1) * (q + 1) <= quot) q++;
        end
        r.depth = q[6:0];
        a = quadrant_phase(dx < 0 ? -dx : dx, dy < 0 ? -dy : dy);
        if (dx < 0) a = (longint'(128) << 16) - a;
        mag = a >>> 16;
        if (dy < 0) mag = -mag;
        r.angle = mag[6:0];
        t = r.depth ^ r.angle;
        r.color = {1'b0, t, 1'b0, t, 1'b0, t, 8'hff};
        return r;
    endfunction

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_valid = 1'b0;
        case (idx)
            CFG_CENTER_X:       ctr_x  = val[8:0];
            CFG_CENTER_Y:       ctr_y  = val[8:0];
            CFG_DISTANCE_SCALE: dscale = val;
            default: ;
        endcase
    endtask

    // wait for the pipe to drain before touching registers
    task automatic drain_pipe();
        while (texels_due.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 2) @(negedge i_clk);
    endtask

    task automatic send_pixel(logic [8:0] col, logic [8:0] row, int gap);
        repeat (gap) @(negedge i_clk);
        s_valid = 1'b1;
        s_data  = {6'd0, row, col};
        texels_due.push_back(map_pixel(col, row));
        @(posedge i_clk);
        while (!s_ready) @(posedge i_clk);
        @(negedge i_clk);
        s_valid = 1'b0;
    endtask

    // receiver: count down a random wait before each beat, long stall when asked
    always @(negedge i_clk) begin
        if (!i_rst_n || hold_off) begin
            m_ready <= 1'b0;
        end else if (rx_wait > 0) begin
            m_ready <= 1'b0;
            rx_wait--;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // check each result beat against the oldest expectation
    always @(posedge i_clk) begin
        texel_t want;
        if (i_rst_n && m_valid && m_ready) begin
            results_seen++;
            rx_wait = $urandom_range(0, 6);
            if (texels_due.size() == 0) begin
                $error("unexpected result beat %h", m_data);
                errors++;
            end else begin
                want = texels_due.pop_front();
                if (m_data[31:0] !== want.color) begin
                    $error("texel_color exp %h got %h", want.color, m_data[31:0]);
                    errors++;
                end
                if (m_data[38:32] !== want.depth) begin
                    $error("depth_index exp %0d got %0d", want.depth, m_data[38:32]);
                    errors++;
                end
                if (m_data[45:39] !== want.angle) begin
                    $error("angle_index exp %0d got %0d", want.angle, m_data[45:39]);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_CAP) begin
            $display("timeout after %0d cycles", cycles);
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        vector_t     vecs[$];
        texel_t      got;
        int          gap;
        logic [8:0]  c, r;
        errors = 0; cycles = 0; results_seen = 0; hold_off = 0; rx_wait = 0;
        i_rst_n = 1'b0; s_valid = 1'b0; s_data = '0;
        cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0; m_ready = 1'b0;
        ctr_x = RST_CENTER_X; ctr_y = RST_CENTER_Y; dscale = RST_DISTANCE_SCALE;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed rows: {cfg idx, cfg val, col, row, known, depth, angle}
        vecs = '{
            '{CFG_UNUSED, 16'd0, 9'd256, 9'd256, 1, 7'd0, 7'd0},     // centre, reset regs
            '{CFG_UNUSED, 16'd0, 9'd300, 9'd256, 0, 7'd0, 7'd0},     // +x axis
            '{CFG_UNUSED, 16'd0, 9'd0,   9'd256, 0, 7'd0, 7'd0},     // -x axis, wraps
            '{CFG_UNUSED, 16'd0, 9'd256, 9'd511, 0, 7'd0, 7'd64},    // +y axis
            '{CFG_UNUSED, 16'd0, 9'd256, 9'd0,   0, 7'd0, 7'd64},    // -y axis
            '{CFG_UNUSED, 16'd0, 9'd356, 9'd356, 0, 7'd0, 7'd32},    // diagonal
            '{CFG_UNUSED, 16'd0, 9'd156, 9'd156, 0, 7'd0, 7'd0},
            '{CFG_UNUSED, 16'd0, 9'd511, 9'd0,   0, 7'd0, 7'd0},
            '{CFG_UNUSED, 16'd0, 9'd257, 9'd258, 0, 7'd0, 7'd0},
            '{CFG_CENTER_X, 16'd0, 9'd0, 9'd256, 1, 7'd0, 7'd0},
            '{CFG_CENTER_Y, 16'd0, 9'd511, 9'd511, 0, 7'd0, 7'd0},
            '{CFG_CENTER_X, 16'd511, 9'd0, 9'd0, 0, 7'd0, 7'd0},
            '{CFG_CENTER_Y, 16'd511, 9'd511, 9'd0, 0, 7'd0, 7'd0},
            '{CFG_DISTANCE_SCALE, 16'd0, 9'd100, 9'd20, 0, 7'd0, 7'd0},
            '{CFG_DISTANCE_SCALE, 16'd65535, 9'd510, 9'd511, 0, 7'd0, 7'd0},
            '{CFG_DISTANCE_SCALE, 16'd1, 9'd511, 9'd510, 0, 7'd0, 7'd0},
            '{CFG_UNUSED, 16'd0, 9'd511, 9'd511, 1, 7'd0, 7'd0}
        };
        foreach (vecs[k]) begin
            if (vecs[k].cfg_idx != CFG_UNUSED) begin
                drain_pipe();
                write_reg(vecs[k].cfg_idx, vecs[k].cfg_val);
            end
            got = map_pixel(vecs[k].col, vecs[k].row);
            if (vecs[k].known && (got.depth !== vecs[k].depth || got.angle !== vecs[k].angle))
            begin
                $error("directed row %0d: depth exp %0d got %0d, angle exp %0d got %0d",
                       k, vecs[k].depth, got.depth, vecs[k].angle, got.angle);
                errors++;
            end
            send_pixel(vecs[k].col, vecs[k].row, $urandom_range(0, 6));
        end
        // unused register index must be ignored
        drain_pipe();
        write_reg(CFG_UNUSED, 16'hffff);

        // random phases with varying settings
        for (int ph = 0; ph < 8; ph++) begin
            drain_pipe();
            write_reg(CFG_CENTER_X, (ph == 0) ? 16'd256 : 16'($urandom_range(0, 511)));
            write_reg(CFG_CENTER_Y, (ph == 0) ? 16'd256 : 16'($urandom_range(0, 511)));
            write_reg(CFG_DISTANCE_SCALE, (ph == 1) ? 16'd65535 : (ph == 2) ? 16'd1 :
                      16'($urandom_range(1, 65535)));
            for (int n = 0; n < N_RANDOM / 8; n++) begin
                if (ph == 3 && n == 20) begin
                    // long receiver stall while the sender keeps offering
                    hold_off = 1;
                    fork
                        begin repeat (120) @(negedge i_clk); hold_off = 0; end
                    join_none
                end
                if (ph == 5 && n == 40) begin
                    // sender pauses until every result is back
                    while (texels_due.size() != 0) @(negedge i_clk);
                end
                c = 9'($urandom_range(0, 511));
                r = 9'($urandom_range(0, 511));
                if ($urandom_range(0, 9) == 0) c = ctr_x;
                if ($urandom_range(0, 9) == 0) r = ctr_y;
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
                if (ph == 6) gap = 0;
                send_pixel(c, r, gap);
            end
        end

        while (texels_due.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 5) @(negedge i_clk);
        $display("covered %0d result beats over reset, extreme and random centre/scale settings",
                 results_seen);
        if (errors == 0 && texels_due.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
